// ===== hw/rtl/dkvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkvp_pkg
// Shared constants for the delimited key/value parser: result kinds,
// register indexes, reset values of the registers, character codes and group part codes.
// ----------------------------------------------------------------------------
package dkvp_pkg;

  // Largest token the stores hold (default for the top-level parameter).
  localparam int MAX_TOKEN_LEN_DEF = 31;

  // Most result beats one payload byte may cause; beats beyond are dropped.
  localparam int MAX_ITEMS = 63;

  // Result kinds.
  localparam logic [2:0] KIND_INT_HDR = 3'd0;
  localparam logic [2:0] KIND_STR_HDR = 3'd1;
  localparam logic [2:0] KIND_FIELD   = 3'd2;
  localparam logic [2:0] KIND_VALUE   = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SKIP_COUNT = 3'd0;
  localparam logic [2:0] REG_SPLIT_BYTE = 3'd1;
  localparam logic [2:0] REG_SPLIT_ON   = 3'd2;
  localparam logic [2:0] REG_DELIM_BYTE = 3'd3;
  localparam logic [2:0] REG_DELIM_ON   = 3'd4;
  localparam logic [2:0] REG_END_BYTE   = 3'd5;
  localparam logic [2:0] REG_END_ON     = 3'd6;

  // Register reset values.
  localparam logic [7:0] SPLIT_BYTE_RST = 8'd58;  // ':'
  localparam logic [7:0] DELIM_BYTE_RST = 8'd44;  // ','
  localparam logic [7:0] END_BYTE_RST   = 8'd10;  // line feed

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Group part codes.
  localparam logic [1:0] PART_FIELD = 2'd0;
  localparam logic [1:0] PART_VALUE = 2'd1;
  localparam logic [1:0] PART_DROP  = 2'd2;

endpackage

// ===== hw/rtl/delimited_key_value_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_key_value_parser
// Byte-serial parser that cuts a packet payload into groups, splits each
// group into field and value, and emits a header plus buffered text beats.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | sink      | in_valid/in_ready  | payload_byte, final_byte
//  out     | source    | out_valid/out_ready| item_kind, text_byte, number_value,
//          |           |                    | field_length, value_length, run_last
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A payload byte is accepted, decoded and finished, with an add step before
//  the finish when it is a digit: the shared 67-bit adder forms acc*10 in one
//  pass and adds the digit in a second. A group close takes a setup step, then emits
//  its result beats; a full output register stalls the sequencer until out_ready.
//  The input is ready only while the sequencer is idle. rst is synchronous and
//  returns the registers to their reset values and the parser to packet start.
//  The configuration port is always ready.
//
module delimited_key_value_parser
  import dkvp_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input bytes
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         payload_byte,
  input  logic               final_byte,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         item_kind,
  output logic [7:0]         text_byte,
  output logic signed [31:0] number_value,
  output logic [4:0]         field_length,
  output logic [4:0]         value_length,
  output logic               run_last,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // Store index and fill widths; the fill also holds "one past full".
  localparam int IDX_W  = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int FILL_W = $clog2(MAX_TOKEN_LEN + 2);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_TOKEN_LEN);
  localparam int ADD_W  = 67;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a payload beat
  localparam logic [2:0] S_BYTE  = 3'd1;  // decode the byte, start acc*10
  localparam logic [2:0] S_ADD   = 3'd2;  // add the digit, check the limit
  localparam logic [2:0] S_FIN   = 3'd3;  // handle the packet's final byte
  localparam logic [2:0] S_CLOSE = 3'd4;  // snapshot the group, clear it
  localparam logic [2:0] S_HDR   = 3'd5;  // emit header or error
  localparam logic [2:0] S_FLD   = 3'd6;  // emit field bytes
  localparam logic [2:0] S_VAL   = 3'd7;  // emit value bytes

  logic [2:0] state;

  // Configuration registers.
  logic [7:0] skip_count_cfg;
  logic [7:0] splitter_byte;
  logic       splitter_on;
  logic [7:0] delimiter_byte;
  logic       delimiter_on;
  logic [7:0] end_byte;
  logic       end_on;

  // Captured input beat.
  logic [7:0] byte_r;
  logic       fin_r;

  // Parse state.
  logic [7:0]        skip_left;
  logic              packet_start;
  logic [1:0]        group_part;
  logic [7:0]        field_store [MAX_TOKEN_LEN];
  logic [7:0]        value_store [MAX_TOKEN_LEN];
  logic [FILL_W-1:0] field_fill;
  logic [FILL_W-1:0] value_fill;
  logic [63:0]       decimal_acc;
  logic [ADD_W-1:0]  acc_times10;
  logic              acc_overflow;
  logic              only_digits;
  logic              saw_split;
  logic              payload_ended;
  logic              packet_failed;

  // Close bookkeeping.
  logic              close_fin;    // close started by the final byte
  logic              close_end;    // close started by end byte or NUL
  logic              close_full;   // close filled every result slot
  logic              more_after;   // a final-byte error beat follows this close
  logic              err_r;
  logic              int_r;
  logic              split_r;
  logic [FILL_W-1:0] flen_r;
  logic [FILL_W-1:0] vlen_r;
  logic [31:0]       num_r;
  logic [IDX_W-1:0]  idx;

  // Shared adder.
  logic [ADD_W-1:0] add_a;
  logic [ADD_W-1:0] add_b;
  logic [ADD_W-1:0] add_sum;

  // Byte decode.
  logic [7:0]  skip_eff;
  logic        active;
  logic        is_end;
  logic        is_delim;
  logic        is_split;
  logic        is_digit;
  logic [3:0]  digit;

  // Close snapshot.
  logic [FILL_W-1:0] c_flen;
  logic [FILL_W-1:0] c_vlen;
  logic              c_err;
  logic              c_full;
  logic [6:0]        c_count;

  // Emission helpers.
  logic              out_free;
  logic [FILL_W-1:0] idx_inc;
  logic              fld_last;
  logic              val_last;
  logic [7:0]        fld_data;
  logic [7:0]        val_data;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // One adder serves both digit passes: acc*8 + acc*2, then + digit.
  always_comb begin
    if (state == S_ADD) begin
      add_a = acc_times10;
      add_b = ADD_W'(digit);
    end else begin
      add_a = {decimal_acc, 3'b000};
      add_b = {1'b0, decimal_acc, 2'b00} >> 1;
    end
    add_sum = add_a + add_b;
  end

  always_comb begin
    skip_eff = packet_start ? skip_count_cfg : skip_left;
    active   = !payload_ended && !packet_failed && (byte_r != CHAR_SPACE);
    is_end   = (byte_r == CHAR_NUL) || (end_on && (byte_r == end_byte));
    is_delim = delimiter_on && (byte_r == delimiter_byte);
    is_split = splitter_on && (byte_r == splitter_byte);
    is_digit = (byte_r >= CHAR_ZERO) && (byte_r <= CHAR_NINE);
    digit    = 4'(byte_r - CHAR_ZERO);
  end

  // Group snapshot: with no splitter the whole group is the value.
  always_comb begin
    c_flen  = saw_split ? field_fill : '0;
    c_vlen  = saw_split ? value_fill : field_fill;
    c_err   = (field_fill > FILL_MAX) || (value_fill > FILL_MAX) ||
              (c_vlen == '0) || (only_digits && acc_overflow);
    c_count = 7'(c_flen) + (only_digits ? 7'd0 : 7'(c_vlen)) + 7'd1;
    c_full  = !c_err && (c_count >= 7'(MAX_ITEMS));
  end

  always_comb begin
    idx_inc  = FILL_W'(idx) + FILL_W'(1);
    fld_last = (idx_inc == flen_r);
    val_last = (idx_inc == vlen_r);
    fld_data = field_store[idx];
    val_data = split_r ? value_store[idx] : field_store[idx];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count_cfg <= '0;
      splitter_byte  <= SPLIT_BYTE_RST;
      splitter_on    <= 1'b0;
      delimiter_byte <= DELIM_BYTE_RST;
      delimiter_on   <= 1'b0;
      end_byte       <= END_BYTE_RST;
      end_on         <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SKIP_COUNT: skip_count_cfg <= cfg_data;
        REG_SPLIT_BYTE: splitter_byte  <= cfg_data;
        REG_SPLIT_ON:   splitter_on    <= cfg_data[0];
        REG_DELIM_BYTE: delimiter_byte <= cfg_data;
        REG_DELIM_ON:   delimiter_on   <= cfg_data[0];
        REG_END_BYTE:   end_byte       <= cfg_data;
        REG_END_ON:     end_on         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Text stores: payload only, written at the fill position while it fits.
  always_ff @(posedge clk) begin
    if (state == S_BYTE && active && skip_eff == '0 && !is_end && !is_delim &&
        !is_split && group_part != PART_DROP) begin
      if (group_part == PART_FIELD) begin
        if (field_fill < FILL_MAX) begin
          field_store[field_fill[IDX_W-1:0]] <= byte_r;
        end
      end else if (value_fill < FILL_MAX) begin
        value_store[value_fill[IDX_W-1:0]] <= byte_r;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      skip_left     <= '0;
      packet_start  <= 1'b1;
      group_part    <= PART_FIELD;
      field_fill    <= '0;
      value_fill    <= '0;
      decimal_acc   <= '0;
      acc_overflow  <= 1'b0;
      only_digits   <= 1'b1;
      saw_split     <= 1'b0;
      payload_ended <= 1'b0;
      packet_failed <= 1'b0;
      close_fin     <= 1'b0;
      close_end     <= 1'b0;
      close_full    <= 1'b0;
      more_after    <= 1'b0;
      idx           <= '0;
    end else begin
      // Drop the result beat once the sink takes it.
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_r     <= payload_byte;
            fin_r      <= final_byte;
            close_fin  <= 1'b0;
            close_full <= 1'b0;
            state      <= S_BYTE;
          end
        end

        S_BYTE: begin
          acc_times10  <= add_sum;
          packet_start <= 1'b0;
          skip_left    <= skip_eff;
          state        <= S_FIN;
          if (active) begin
            if (skip_eff != '0) begin
              skip_left <= skip_eff - 8'd1;
            end else if (is_end || is_delim) begin
              close_end <= is_end;
              state     <= S_CLOSE;
            end else if (is_split) begin
              if (group_part == PART_FIELD) begin
                group_part   <= PART_VALUE;
                saw_split    <= 1'b1;
                decimal_acc  <= '0;
                acc_overflow <= 1'b0;
                only_digits  <= 1'b1;
              end else begin
                group_part <= PART_DROP;
              end
            end else if (group_part != PART_DROP) begin
              // Collect: count one past full so a long token is caught at close.
              if (group_part == PART_FIELD) begin
                if (field_fill <= FILL_MAX) begin
                  field_fill <= field_fill + FILL_W'(1);
                end
              end else if (value_fill <= FILL_MAX) begin
                value_fill <= value_fill + FILL_W'(1);
              end
              if (!is_digit) begin
                only_digits <= 1'b0;
              end else if (!acc_overflow) begin
                state <= S_ADD;
              end
            end
          end
        end

        S_ADD: begin
          // acc*10 + d above 2^63-1 flags the value as too large.
          if (add_sum[ADD_W-1:63] != '0) begin
            acc_overflow <= 1'b1;
          end else begin
            decimal_acc <= add_sum[63:0];
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (fin_r && !close_fin && !payload_ended && !packet_failed && !close_full) begin
            close_fin <= 1'b1;
            close_end <= 1'b0;
            state     <= S_CLOSE;
          end else begin
            if (fin_r) begin
              // Start a new packet.
              group_part    <= PART_FIELD;
              field_fill    <= '0;
              value_fill    <= '0;
              saw_split     <= 1'b0;
              decimal_acc   <= '0;
              acc_overflow  <= 1'b0;
              only_digits   <= 1'b1;
              payload_ended <= 1'b0;
              packet_failed <= 1'b0;
              packet_start  <= 1'b1;
              skip_left     <= '0;
            end
            state <= S_IDLE;
          end
        end

        S_CLOSE: begin
          err_r      <= c_err;
          int_r      <= only_digits;
          split_r    <= saw_split;
          flen_r     <= c_flen;
          vlen_r     <= c_vlen;
          num_r      <= decimal_acc[31:0];
          close_full <= c_full;
          more_after <= !close_fin && fin_r && !close_end && !c_err && !c_full;
          idx        <= '0;
          if (c_err) begin
            packet_failed <= 1'b1;
          end
          if (close_end) begin
            payload_ended <= 1'b1;
          end
          // Clear the group; the snapshot carries what emission needs.
          group_part   <= PART_FIELD;
          field_fill   <= '0;
          value_fill   <= '0;
          saw_split    <= 1'b0;
          decimal_acc  <= '0;
          acc_overflow <= 1'b0;
          only_digits  <= 1'b1;
          state        <= S_HDR;
        end

        S_HDR: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            text_byte    <= '0;
            number_value <= '0;
            field_length <= '0;
            value_length <= '0;
            if (err_r) begin
              item_kind <= KIND_ERROR;
              run_last  <= !more_after;
              state     <= S_FIN;
            end else begin
              item_kind    <= int_r ? KIND_INT_HDR : KIND_STR_HDR;
              number_value <= int_r ? num_r : 32'd0;
              field_length <= 5'(flen_r);
              value_length <= int_r ? 5'd0 : 5'(vlen_r);
              run_last     <= !more_after && int_r && (flen_r == '0);
              if (flen_r != '0) begin
                state <= S_FLD;
              end else if (!int_r) begin
                state <= S_VAL;
              end else begin
                state <= S_FIN;
              end
            end
          end
        end

        S_FLD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            item_kind    <= KIND_FIELD;
            text_byte    <= fld_data;
            number_value <= '0;
            field_length <= '0;
            value_length <= '0;
            run_last     <= !more_after && int_r && fld_last;
            if (fld_last) begin
              idx   <= '0;
              state <= int_r ? S_FIN : S_VAL;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end

        S_VAL: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            item_kind    <= KIND_VALUE;
            text_byte    <= val_data;
            number_value <= '0;
            field_length <= '0;
            value_length <= '0;
            run_last     <= !more_after && val_last;
            if (val_last) begin
              idx   <= '0;
              state <= S_FIN;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The accumulator never passes 2^63-1.
  a_acc_limit: assert property (@(posedge clk) disable iff (rst)
    !decimal_acc[63])
    else $error("decimal accumulator above 2^63-1");

  // Fills stop one past the store depth.
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    (field_fill <= FILL_MAX + FILL_W'(1)) && (value_fill <= FILL_MAX + FILL_W'(1)))
    else $error("token fill ran past its cap");

  // A taken input beat keeps the input closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while a byte is in work");

  // A new result beat only loads from an emission state.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_HDR || $past(state) == S_FLD ||
                          $past(state) == S_VAL))
    else $error("result beat loaded outside emission");
`endif

endmodule
